>>> src/lts_pkg.sv
`default_nettype none

package lts_pkg;

	localparam int LENGTH_BITS_DEFAULT = 16;
	localparam int OFFSET_BITS_DEFAULT = 32;

	// Port widths of one token word
	localparam int TOK_LEN_W = 16;
	localparam int TOK_OFF_W = 32;

	// Token queue between scanner and output stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int NUM_KW   = 20;
	localparam int KW_IDX_W = 5;
	localparam int KW_SLOTS = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM,
		ST_WORD,
		ST_LT,
		ST_GT,
		ST_COLON
	} scan_state_t;

	typedef enum logic [3:0] {
		CLS_NUMERAL,
		CLS_IDENT,
		CLS_KEYWORD,
		CLS_WEAK_OP,
		CLS_STRONG_OP,
		CLS_RELATION,
		CLS_SEMI,
		CLS_COMMA,
		CLS_LPAREN,
		CLS_RPAREN,
		CLS_ASSIGN,
		CLS_COLON,
		CLS_LBRACKET,
		CLS_RBRACKET,
		CLS_ERROR,
		CLS_END
	} tok_class_t;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_LT,
		OP_NE,
		OP_LE,
		OP_GT,
		OP_GE,
		OP_EQ
	} op_code_t;

	typedef struct packed {
		tok_class_t             cls;
		logic [KW_IDX_W-1:0]    kw;
		op_code_t               op;
		logic [TOK_OFF_W-1:0]   start;
		logic [TOK_LEN_W-1:0]   len;
	} tok_t;

	// One queue entry: the tokens caused by one input byte
	typedef struct packed {
		tok_t t0;
		tok_t t1;
		logic two;
	} entry_t;

	// Keyword text, right-justified, last character in the low byte
	localparam logic [8*KW_SLOTS-1:0] KW_TEXT [NUM_KW] = '{
		64'("true"), 64'("false"), 64'("and"), 64'("or"), 64'("read"),
		64'("write"), 64'("if"), 64'("then"), 64'("endif"), 64'("while"),
		64'("do"), 64'("end"), 64'("begin"), 64'("program"), 64'("is"),
		64'("var"), 64'("integer"), 64'("boolean"), 64'("not"), 64'("skip")
	};

	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5, 3'd5,
		3'd2, 3'd3, 3'd5, 3'd7, 3'd2, 3'd3, 3'd7, 3'd7, 3'd3, 3'd4
	};

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

`default_nettype wire

>>> src/lts_front.sv
`default_nettype none

module lts_front
	import lts_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  char_byte,
	input  wire logic        end_of_input,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             q_push,
	output entry_t           q_entry,
	input  wire logic        q_full
);

	scan_state_t              state_q, state_d;
	logic [NUM_KW-1:0]        cand_q, cand_d;
	logic [LENGTH_BITS-1:0]   len_q, len_d, len_inc;
	logic [OFFSET_BITS-1:0]   start_q, start_d, pos_q, pos_d;

	logic                     acc, is_dig, is_let, is_sp, len_small;
	logic [NUM_KW-1:0]        keep_vec, keep0;
	logic                     kw_hit;
	logic [KW_IDX_W-1:0]      kw_idx;
	logic                     pend_valid, fresh_valid;
	tok_t                     pend_tok, fresh_tok, end_tok, two_tok;
	scan_state_t              fresh_state;

	function automatic tok_t mk_tok(input tok_class_t cls, input logic [KW_IDX_W-1:0] kw,
			input op_code_t op, input logic [TOK_OFF_W-1:0] start,
			input logic [TOK_LEN_W-1:0] len);
		tok_t t;
		t.cls   = cls;
		t.kw    = kw;
		t.op    = op;
		t.start = start;
		t.len   = len;
		return t;
	endfunction

	function automatic logic [7:0] kw_byte(input logic [KW_IDX_W-1:0] k, input logic [2:0] p);
		logic [8*KW_SLOTS-1:0] t;
		logic [2:0]            l;
		logic [2:0]            sh;
		t  = KW_TEXT[k];
		l  = KW_LEN[k];
		sh = l - 3'd1 - p;
		return (p < l) ? t[{sh, 3'b000} +: 8] : 8'd0;
	endfunction

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	assign is_dig    = (char_byte >= "0") && (char_byte <= "9");
	assign is_let    = ((char_byte >= "a") && (char_byte <= "z")) ||
	                   ((char_byte >= "A") && (char_byte <= "Z"));
	assign is_sp     = (char_byte == CH_SPACE) || ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
	assign len_small = (len_q >> 3) == '0;
	assign len_inc   = (len_q == '1) ? len_q : len_q + 1'b1;

	// Per-keyword character compare at the current and the first position
	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			keep_vec[k] = len_small && (kw_byte(KW_IDX_W'(k), len_q[2:0]) == char_byte);
			keep0[k]    = kw_byte(KW_IDX_W'(k), 3'd0) == char_byte;
		end
	end

	// Lowest surviving keyword whose length matches
	always_comb begin
		kw_hit = 1'b0;
		kw_idx = '0;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (cand_q[k] && (len_q == LENGTH_BITS'(KW_LEN[k]))) begin
				kw_hit = 1'b1;
				kw_idx = KW_IDX_W'(k);
			end
		end
	end

	// Token that closes when the current byte cannot extend it
	always_comb begin
		pend_valid = 1'b1;
		pend_tok   = mk_tok(CLS_NUMERAL, '0, OP_ADD, TOK_OFF_W'(start_q), TOK_LEN_W'(len_q));
		case (state_q)
			ST_NUM: begin
			end
			ST_WORD: begin
				pend_tok.cls = kw_hit ? CLS_KEYWORD : CLS_IDENT;
				pend_tok.kw  = kw_hit ? kw_idx : '0;
			end
			ST_LT: begin
				pend_tok = mk_tok(CLS_RELATION, '0, OP_LT, TOK_OFF_W'(start_q), TOK_LEN_W'(1));
			end
			ST_GT: begin
				pend_tok = mk_tok(CLS_RELATION, '0, OP_GT, TOK_OFF_W'(start_q), TOK_LEN_W'(1));
			end
			ST_COLON: begin
				pend_tok = mk_tok(CLS_COLON, '0, OP_ADD, TOK_OFF_W'(start_q), TOK_LEN_W'(1));
			end
			default: begin
				pend_valid = 1'b0;
			end
		endcase
	end

	// Byte scanned from the idle state
	always_comb begin
		fresh_valid = 1'b1;
		fresh_state = ST_IDLE;
		fresh_tok   = mk_tok(CLS_ERROR, '0, OP_ADD, TOK_OFF_W'(pos_q), TOK_LEN_W'(1));
		if (is_sp) begin
			fresh_valid = 1'b0;
		end else if (is_dig) begin
			fresh_valid = 1'b0;
			fresh_state = ST_NUM;
		end else if (is_let) begin
			fresh_valid = 1'b0;
			fresh_state = ST_WORD;
		end else begin
			case (char_byte)
				CH_PLUS:  begin fresh_tok.cls = CLS_WEAK_OP;   fresh_tok.op = OP_ADD; end
				CH_MINUS: begin fresh_tok.cls = CLS_WEAK_OP;   fresh_tok.op = OP_SUB; end
				CH_STAR:  begin fresh_tok.cls = CLS_STRONG_OP; fresh_tok.op = OP_MUL; end
				CH_SLASH: begin fresh_tok.cls = CLS_STRONG_OP; fresh_tok.op = OP_DIV; end
				CH_EQ:    begin fresh_tok.cls = CLS_RELATION;  fresh_tok.op = OP_EQ;  end
				CH_SEMI:  fresh_tok.cls = CLS_SEMI;
				CH_COMMA: fresh_tok.cls = CLS_COMMA;
				CH_LPAR:  fresh_tok.cls = CLS_LPAREN;
				CH_RPAR:  fresh_tok.cls = CLS_RPAREN;
				CH_LBRK:  fresh_tok.cls = CLS_LBRACKET;
				CH_RBRK:  fresh_tok.cls = CLS_RBRACKET;
				CH_LT:    begin fresh_valid = 1'b0; fresh_state = ST_LT;    end
				CH_GT:    begin fresh_valid = 1'b0; fresh_state = ST_GT;    end
				CH_COLON: begin fresh_valid = 1'b0; fresh_state = ST_COLON; end
				default:  fresh_tok.cls = CLS_ERROR;
			endcase
		end
	end

	assign end_tok = mk_tok(CLS_END, '0, OP_ADD, TOK_OFF_W'(pos_q), '0);

	// Next state and queue push
	always_comb begin
		logic two_valid;
		logic extend;
		state_d   = state_q;
		cand_d    = cand_q;
		len_d     = len_q;
		start_d   = start_q;
		pos_d     = pos_q;
		q_push    = 1'b0;
		q_entry   = '0;
		two_valid = 1'b0;
		extend    = 1'b0;
		two_tok   = mk_tok(CLS_RELATION, '0, OP_NE, TOK_OFF_W'(start_q), TOK_LEN_W'(2));
		if (acc) begin
			if (end_of_input) begin
				q_push = 1'b1;
				if (pend_valid) begin
					q_entry.t0  = pend_tok;
					q_entry.t1  = end_tok;
					q_entry.two = 1'b1;
				end else begin
					q_entry.t0 = end_tok;
				end
				state_d = ST_IDLE;
				cand_d  = '1;
				len_d   = '0;
				start_d = '0;
				pos_d   = '0;
			end else begin
				case (state_q)
					ST_NUM: begin
						extend = is_dig;
					end
					ST_WORD: begin
						extend = is_dig || is_let;
					end
					ST_LT: begin
						if (char_byte == CH_GT) begin
							two_valid = 1'b1;
						end else if (char_byte == CH_EQ) begin
							two_valid  = 1'b1;
							two_tok.op = OP_LE;
						end
					end
					ST_GT: begin
						two_valid  = char_byte == CH_EQ;
						two_tok.op = OP_GE;
					end
					ST_COLON: begin
						two_valid   = char_byte == CH_EQ;
						two_tok.cls = CLS_ASSIGN;
						two_tok.op  = OP_ADD;
					end
					default: begin
					end
				endcase

				if (extend) begin
					len_d = len_inc;
					if (state_q == ST_WORD) begin
						cand_d = cand_q & keep_vec;
					end
				end else if (two_valid) begin
					q_push     = 1'b1;
					q_entry.t0 = two_tok;
					state_d    = ST_IDLE;
				end else begin
					// close what is pending, then rescan the byte from idle
					state_d = fresh_state;
					if (fresh_state != ST_IDLE) begin
						start_d = pos_q;
						len_d   = LENGTH_BITS'(1);
						if (fresh_state == ST_WORD) begin
							cand_d = keep0;
						end
					end
					q_push = pend_valid || fresh_valid;
					if (pend_valid) begin
						q_entry.t0  = pend_tok;
						q_entry.t1  = fresh_tok;
						q_entry.two = fresh_valid;
					end else begin
						q_entry.t0 = fresh_tok;
					end
				end
				pos_d = pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cand_q  <= '1;
			len_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			cand_q  <= cand_d;
			len_q   <= len_d;
			start_q <= start_d;
			pos_q   <= pos_d;
		end
	end

endmodule

`default_nettype wire

>>> src/lts_queue.sv
`default_nettype none

module lts_queue
	import lts_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire entry_t  push_entry,
	output logic         full,
	input  wire logic    pop,
	output entry_t       head,
	output logic         empty
);

	entry_t            ent_q [QDEPTH];
	logic [QPTR_W:0]   wr_ptr_q, rd_ptr_q;

	assign empty = wr_ptr_q == rd_ptr_q;
	assign full  = (wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]) &&
	               (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W]);
	assign head  = ent_q[rd_ptr_q[QPTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_ptr_q[QPTR_W-1:0]] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/lts_back.sv
`default_nettype none

module lts_back
	import lts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire entry_t            head,
	input  wire logic              empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [3:0]             token_class,
	output logic [KW_IDX_W-1:0]    keyword_index,
	output logic [3:0]             operator_code,
	output logic [TOK_OFF_W-1:0]   start_offset,
	output logic [TOK_LEN_W-1:0]   lexeme_length,
	output logic                   last_of_run
);

	logic  out_valid_q, second_q, load;
	tok_t  tok_q;
	logic  last_q;

	// Take the next token when the output register is free or drains now
	assign load = !empty && (!out_valid_q || out_ready);
	assign pop  = load && (!head.two || second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= head.two && !second_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= second_q ? head.t1 : head.t0;
			last_q <= !head.two || second_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign token_class   = tok_q.cls;
	assign keyword_index = tok_q.kw;
	assign operator_code = tok_q.op;
	assign start_offset  = tok_q.start;
	assign lexeme_length = tok_q.len;
	assign last_of_run   = last_q;

endmodule

`default_nettype wire

>>> src/lexical_token_scanner.sv
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_ready   char_byte, end_of_input
// out      output     out_valid / out_ready token_class, keyword_index, operator_code,
//                                           start_offset, lexeme_length, last_of_run
//
// One byte is accepted every cycle while the token queue has room; each byte
// yields zero, one or two token words.
// The output register hands out one token word per cycle while out_ready is high,
// so a byte that both closes a pending token and forms its own yields two words in turn.
// Each token word is written to the queue, then loaded into the output register for out.
// Reset clears the scanner state, byte position and queue; an end-of-input
// word does the same to the scanner state once its tokens are queued.
// An output stall first fills the four-entry queue, then drops in_ready.
`default_nettype none

module lexical_token_scanner
	import lts_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   char_byte,
	input  wire logic         end_of_input,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [3:0]        token_class,
	output logic [4:0]        keyword_index,
	output logic [3:0]        operator_code,
	output logic [31:0]       start_offset,
	output logic [15:0]       lexeme_length,
	output logic              last_of_run
);

	// Scanner to queue
	logic    q_push, q_full;
	entry_t  q_entry;

	// Queue to output stage
	logic    q_pop, q_empty;
	entry_t  q_head;

	// Front: run the DFA and keyword mask, push the tokens of each byte
	lts_front #(
		.LENGTH_BITS (LENGTH_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.q_push       (q_push),
		.q_entry      (q_entry),
		.q_full       (q_full)
	);

	// Queue: hold up to four bytes' worth of tokens so each side stalls alone
	lts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	// Back: split each entry into single token words, mark the last one
	lts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_class   (token_class),
		.keyword_index (keyword_index),
		.operator_code (operator_code),
		.start_offset  (start_offset),
		.lexeme_length (lexeme_length),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire

>>> src/lts_checker.sv
`default_nettype none

module lts_checker
	import lts_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [3:0]   token_class,
	input wire logic [4:0]   keyword_index,
	input wire logic [3:0]   operator_code,
	input wire logic [31:0]  start_offset,
	input wire logic [15:0]  lexeme_length,
	input wire logic         last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_class) &&
		$stable(keyword_index) && $stable(operator_code) && $stable(start_offset) &&
		$stable(lexeme_length) && $stable(last_of_run))
		else $error("output word changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_class == CLS_END |-> last_of_run && lexeme_length == '0)
		else $error("end token not last or not empty");

	a_kw_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_class != CLS_KEYWORD |-> keyword_index == '0)
		else $error("keyword index on a non-keyword token");

	a_op_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_class != CLS_WEAK_OP && token_class != CLS_STRONG_OP &&
		token_class != CLS_RELATION |-> operator_code == '0)
		else $error("operator code on a non-operator token");

	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_class == CLS_SEMI || token_class == CLS_COMMA ||
		token_class == CLS_LPAREN || token_class == CLS_RPAREN ||
		token_class == CLS_LBRACKET || token_class == CLS_RBRACKET ||
		token_class == CLS_ERROR) |-> lexeme_length == 16'd1)
		else $error("single-character token with wrong length");

endmodule

bind lexical_token_scanner lts_checker u_lts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.token_class   (token_class),
	.keyword_index (keyword_index),
	.operator_code (operator_code),
	.start_offset  (start_offset),
	.lexeme_length (lexeme_length),
	.last_of_run   (last_of_run)
);

`default_nettype wire
